// ===== rtl/swmc_pkg.sv =====
// Shared types, constants and weight table for the stereo window match cost block.
package swmc_pkg;

    localparam int CountW      = 11;
    localparam int SumW        = 48;
    localparam int RomDepth    = 1024;
    localparam int RomAddrW    = 10;
    localparam int WeightW     = 16;
    localparam int QueueDepth  = 4;
    localparam int QueuePtrW   = 2;
    localparam int DivSteps    = 24;
    localparam int DivStepW    = 5;
    localparam logic [CountW-1:0] CountCap = 11'd2047;

    localparam logic [1:0] ADDR_INV_GAMMA      = 2'd0;
    localparam logic [1:0] ADDR_ALPHA          = 2'd1;
    localparam logic [1:0] ADDR_COLOUR_TRUNC   = 2'd2;
    localparam logic [1:0] ADDR_GRADIENT_TRUNC = 2'd3;

    // Taylor terms of exp(-1/64) in Q62, each one the previous over 64*n
    localparam logic [63:0] OneQ62 = 64'd1 << 62;
    localparam logic [63:0] Term1  = OneQ62 / 64'd64;
    localparam logic [63:0] Term2  = Term1 / 64'd128;
    localparam logic [63:0] Term3  = Term2 / 64'd192;
    localparam logic [63:0] Term4  = Term3 / 64'd256;
    localparam logic [63:0] Term5  = Term4 / 64'd320;
    localparam logic [63:0] Term6  = Term5 / 64'd384;
    localparam logic [63:0] Term7  = Term6 / 64'd448;
    localparam logic [63:0] Term8  = Term7 / 64'd512;
    localparam logic [63:0] Term9  = Term8 / 64'd576;
    localparam logic [63:0] Term10 = Term9 / 64'd640;
    localparam logic [63:0] Term11 = Term10 / 64'd704;
    localparam logic [63:0] Term12 = Term11 / 64'd768;
    localparam logic [63:0] WeightStep = OneQ62 - Term1 + Term2 - Term3 + Term4 - Term5
        + Term6 - Term7 + Term8 - Term9 + Term10 - Term11 + Term12;

    typedef struct packed {
        logic [7:0] center_intensity;
        logic [7:0] neighbour_intensity;
        logic [7:0] matched_intensity;
        logic [7:0] neighbour_gradient;
        logic [7:0] matched_gradient;
        logic       match_visible;
        logic       last_in_window;
    } in_item_t;

    typedef struct packed {
        logic [11:0] window_cost;
        logic [10:0] used_neighbours;
        logic        window_empty;
    } out_item_t;

    typedef struct packed {
        logic [11:0] inv_gamma;
        logic [8:0]  alpha;
        logic [11:0] colour_trunc;
        logic [11:0] gradient_trunc;
    } cfg_t;

    // classified neighbour passed from the front end to the datapath
    typedef struct packed {
        logic        keep;
        logic        last;
        logic [7:0]  dcen;
        logic [11:0] cpart;
        logic [11:0] gpart;
    } fe_item_t;

    typedef logic [WeightW-1:0] weight_rom_t [0:RomDepth-1];

    function automatic logic [63:0] mul_shr62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // W[k] = round(65535*exp(-k/64)) built with Q62 arithmetic
    function automatic weight_rom_t build_weight_rom();
        weight_rom_t rom;
        logic [63:0] v;
        logic [63:0] twice;
        v = OneQ62;
        for (int k = 0; k < RomDepth; k++)
        begin
            twice  = mul_shr62(64'd131070, v);
            rom[k] = WeightW'((twice + 64'd1) >> 1);
            v      = mul_shr62(v, WeightStep);
        end
        return rom;
    endfunction

    localparam weight_rom_t WeightRom = build_weight_rom();

endpackage

// ===== rtl/stereo_window_match_cost.sv =====
// Path: a neighbour passes the front register, the queue and stages s1, s2, s3 to the
// accumulator; a last one starts the 24-step divider, whose steps an empty window skips.
// Throughput: one neighbour per cycle while the divider is idle; each last neighbour
// holds the datapath through the divide and any output stall, front register and queue taking 5.
// Reset (rst_n low, asynchronous): registers return to their reset values, the
// running sum, count, queue and all valid flags clear.
module stereo_window_match_cost
#(
    parameter int MAX_WINDOW_PIXELS = 1225
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  swmc_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output swmc_pkg::out_item_t out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import swmc_pkg::*;

    cfg_t     cfg_reg;
    logic     cfg_we;
    logic [1:0] reg_sel;
    logic     fe_valid, fe_full, q_pop, q_nonempty;
    fe_item_t fe_item, q_head;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inv_gamma      <= 12'd410;
            cfg_reg.alpha          <= 9'd230;
            cfg_reg.colour_trunc   <= 12'd160;
            cfg_reg.gradient_trunc <= 12'd32;
        end
        else if (cfg_we)
        begin
            unique case (reg_sel)
                ADDR_INV_GAMMA:      cfg_reg.inv_gamma      <= pwdata[11:0];
                ADDR_ALPHA:          cfg_reg.alpha          <= pwdata[8:0];
                ADDR_COLOUR_TRUNC:   cfg_reg.colour_trunc   <= pwdata[11:0];
                ADDR_GRADIENT_TRUNC: cfg_reg.gradient_trunc <= pwdata[11:0];
                default:             cfg_reg.inv_gamma      <= cfg_reg.inv_gamma;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            ADDR_INV_GAMMA:      prdata = {20'd0, cfg_reg.inv_gamma};
            ADDR_ALPHA:          prdata = {23'd0, cfg_reg.alpha};
            ADDR_COLOUR_TRUNC:   prdata = {20'd0, cfg_reg.colour_trunc};
            ADDR_GRADIENT_TRUNC: prdata = {20'd0, cfg_reg.gradient_trunc};
            default:             prdata = '0;
        endcase
    end

    swmc_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .cfg      (cfg_reg),
        .fe_valid (fe_valid),
        .fe_item  (fe_item),
        .fe_full  (fe_full)
    );

    swmc_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fe_valid),
        .push_item (fe_item),
        .full      (fe_full),
        .pop       (q_pop),
        .nonempty  (q_nonempty),
        .head      (q_head)
    );

    swmc_back #(.MAX_WINDOW_PIXELS(MAX_WINDOW_PIXELS)) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_nonempty (q_nonempty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );
endmodule

// ===== rtl/swmc_front.sv =====
// Input stage: register one neighbour and classify it for the datapath.
module swmc_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  swmc_pkg::in_item_t in_data,
    input  swmc_pkg::cfg_t    cfg,
    output logic              fe_valid,
    output swmc_pkg::fe_item_t fe_item,
    input  logic              fe_full
);
    import swmc_pkg::*;

    logic     valid_reg, valid_next;
    fe_item_t item_reg, item_next;
    logic     accept;
    logic [7:0] dm, dg;
    logic [11:0] dm4, dg4;

    assign in_stall = valid_reg && fe_full;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        dm  = (in_data.neighbour_intensity > in_data.matched_intensity)
            ? in_data.neighbour_intensity - in_data.matched_intensity
            : in_data.matched_intensity - in_data.neighbour_intensity;
        dg  = (in_data.neighbour_gradient > in_data.matched_gradient)
            ? in_data.neighbour_gradient - in_data.matched_gradient
            : in_data.matched_gradient - in_data.neighbour_gradient;
        dm4 = {dm, 4'd0};
        dg4 = {dg, 4'd0};
        item_next.keep = (in_data.neighbour_intensity != 8'd0);
        item_next.last = in_data.last_in_window;
        item_next.dcen = (in_data.neighbour_intensity > in_data.center_intensity)
            ? in_data.neighbour_intensity - in_data.center_intensity
            : in_data.center_intensity - in_data.neighbour_intensity;
        if (in_data.match_visible)
        begin
            item_next.cpart = (dm4 < cfg.colour_trunc) ? dm4 : cfg.colour_trunc;
            item_next.gpart = (dg4 < cfg.gradient_trunc) ? dg4 : cfg.gradient_trunc;
        end
        else
        begin
            item_next.cpart = cfg.colour_trunc;
            item_next.gpart = cfg.gradient_trunc;
        end
        if (accept)
            valid_next = 1'b1;
        else if (!fe_full)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item_next;
    end

    assign fe_valid = valid_reg;
    assign fe_item  = item_reg;
endmodule

// ===== rtl/swmc_queue.sv =====
// Short queue between the front end and the datapath.
module swmc_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  swmc_pkg::fe_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               nonempty,
    output swmc_pkg::fe_item_t head
);
    import swmc_pkg::*;

    fe_item_t               slot_reg [QueueDepth];
    logic [QueuePtrW-1:0]   wr_reg, wr_next, rd_reg, rd_next;
    logic [QueuePtrW:0]     cnt_reg, cnt_next;
    logic                   do_push, do_pop;

    assign full     = (cnt_reg == (QueuePtrW+1)'(QueueDepth));
    assign nonempty = (cnt_reg != '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;
    assign head     = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (QueuePtrW+1)'(do_push) - (QueuePtrW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_reg] <= push_item;
    end
endmodule

// ===== rtl/swmc_back.sv =====
// Datapath: weight lookup, penalty, accumulate and mean division per window.
module swmc_back
#(
    parameter int MAX_WINDOW_PIXELS = 1225
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  swmc_pkg::cfg_t     cfg,
    input  logic               q_nonempty,
    input  swmc_pkg::fe_item_t q_head,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output swmc_pkg::out_item_t out_data
);
    import swmc_pkg::*;

    localparam int LimitInt = (MAX_WINDOW_PIXELS < 2047) ? MAX_WINDOW_PIXELS : 2047;
    localparam logic [CountW-1:0] Limit = CountW'(LimitInt);

    logic        adv;
    logic [8:0]  a_sat;

    logic        s1_valid_reg, s1_keep_reg, s1_last_reg;
    logic [19:0] s1_kprod_reg;
    logic [20:0] s1_cmul_reg;
    logic [11:0] s1_gpart_reg;
    logic        s2_valid_reg, s2_keep_reg, s2_last_reg;
    logic [WeightW-1:0] s2_w_reg;
    logic [20:0] s2_pen_reg;
    logic        s3_valid_reg, s3_keep_reg, s3_last_reg;
    logic [36:0] s3_wp_reg;
    logic [RomAddrW-1:0] k_idx;

    logic [SumW-1:0]   sum_reg, sum_next;
    logic [CountW-1:0] count_reg, count_next;
    logic              kept;

    logic              busy_reg;
    logic [DivStepW-1:0] iter_reg;
    logic [23:0]       quo_reg;
    logic [CountW:0]   rem_reg;
    logic [CountW-1:0] dvs_reg;
    logic              empty_reg;
    logic [CountW:0]   trial;
    logic              finish;

    logic              out_valid_reg;
    out_item_t         out_reg;

    assign adv   = !busy_reg;
    assign q_pop = adv && q_nonempty;
    assign a_sat = (cfg.alpha > 9'd256) ? 9'd256 : cfg.alpha;
    assign k_idx = (s1_kprod_reg[19:6] > 14'd1023) ? RomAddrW'(1023) : s1_kprod_reg[15:6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= q_nonempty;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_keep_reg  <= q_head.keep;
            s1_last_reg  <= q_head.last;
            s1_kprod_reg <= 20'(q_head.dcen) * 20'(cfg.inv_gamma);
            s1_cmul_reg  <= 21'(9'd256 - a_sat) * 21'(q_head.cpart);
            s1_gpart_reg <= q_head.gpart;
            s2_keep_reg  <= s1_keep_reg;
            s2_last_reg  <= s1_last_reg;
            s2_w_reg     <= WeightRom[k_idx];
            s2_pen_reg   <= s1_cmul_reg + 21'(a_sat) * 21'(s1_gpart_reg);
            s3_keep_reg  <= s2_keep_reg;
            s3_last_reg  <= s2_last_reg;
            s3_wp_reg    <= 37'(s2_w_reg) * 37'(s2_pen_reg);
        end
    end

    always_comb
    begin
        kept       = s3_keep_reg && (count_reg < Limit);
        sum_next   = sum_reg + (kept ? SumW'(s3_wp_reg) : '0);
        count_next = count_reg + CountW'(kept);
        trial      = {rem_reg[CountW-1:0], quo_reg[23]};
        finish     = busy_reg && (iter_reg == '0) && (!out_valid_reg || !out_stall);
    end

    // accumulate, then on the window's last neighbour run a restoring divide unless the window is empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
            busy_reg  <= 1'b0;
            iter_reg  <= '0;
        end
        else if (adv && s3_valid_reg)
        begin
            if (s3_last_reg)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
                busy_reg  <= 1'b1;
                iter_reg  <= (count_next == '0) ? '0 : DivStepW'(DivSteps);
            end
            else
            begin
                sum_reg   <= sum_next;
                count_reg <= count_next;
            end
        end
        else if (busy_reg)
        begin
            if (iter_reg != '0)
                iter_reg <= iter_reg - 1'b1;
            else if (finish)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s3_valid_reg && s3_last_reg)
        begin
            quo_reg   <= sum_next[47:24];
            rem_reg   <= '0;
            dvs_reg   <= count_next;
            empty_reg <= (count_next == '0);
        end
        else if (busy_reg && iter_reg != '0)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_reg <= trial - {1'b0, dvs_reg};
                quo_reg <= {quo_reg[22:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[22:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (finish)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_reg.window_empty    <= empty_reg;
            out_reg.used_neighbours <= empty_reg ? '0 : dvs_reg;
            if (empty_reg)
                out_reg.window_cost <= '0;
            else if (quo_reg > 24'd4095)
                out_reg.window_cost <= 12'd4095;
            else
                out_reg.window_cost <= quo_reg[11:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
endmodule

// ===== rtl/swmc_checker.sv =====
// Port-level checks for the stereo window match cost block, bound to the top level.
module swmc_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input swmc_pkg::out_item_t out_data
);
    import swmc_pkg::*;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.window_empty |->
            out_data.window_cost == 12'd0 && out_data.used_neighbours == 11'd0)
        else $error("empty window with nonzero cost or count");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.window_empty |-> out_data.used_neighbours != 11'd0)
        else $error("nonempty window with zero count");
endmodule

bind stereo_window_match_cost swmc_checker u_swmc_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
